### rtl/core/attd_pkg.sv
// Package: register indexes, phase and gesture codes, field widths and reset values.
package attd_pkg;

  localparam int RawW     = 10;
  localparam int NowW     = 32;
  localparam int ThrW     = 10;
  localparam int MsW      = 16;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int GestW    = 3;
  localparam int CountW   = 4;
  localparam int PhaseW   = 2;
  localparam int InDataW  = 48;
  localparam int OutDataW = 8;

  localparam logic [CfgAddrW-1:0] REG_HIGH_THR  = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_LOW_THR   = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_TAP_GAP   = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_HOLD      = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_SAMPLE_IV = 3'd4;

  localparam logic [ThrW-1:0] HIGH_THR_RST  = 10'd700;
  localparam logic [ThrW-1:0] LOW_THR_RST   = 10'd300;
  localparam logic [MsW-1:0]  TAP_GAP_RST   = 16'd500;
  localparam logic [MsW-1:0]  HOLD_RST      = 16'd2000;
  localparam logic [MsW-1:0]  SAMPLE_IV_RST = 16'd30;

  localparam logic [PhaseW-1:0] PH_IDLE  = 2'd0;
  localparam logic [PhaseW-1:0] PH_COUNT = 2'd1;
  localparam logic [PhaseW-1:0] PH_HOLD  = 2'd2;

  localparam logic [GestW-1:0] GEST_NONE   = 3'd0;
  localparam logic [GestW-1:0] GEST_SINGLE = 3'd1;
  localparam logic [GestW-1:0] GEST_DOUBLE = 3'd2;
  localparam logic [GestW-1:0] GEST_TRIPLE = 3'd3;
  localparam logic [GestW-1:0] GEST_HOLD   = 3'd4;

  localparam logic [CountW-1:0] COUNT_MAX = 4'd15;

  typedef struct packed {
    logic [GestW-1:0] gesture;
    logic             touched;
    logic             sample_taken;
  } result_t;

endpackage

### rtl/core/analog_touch_tap_hold_detector_core.sv
// Top level: touch tap and hold detector with sample gate, hysteresis and gesture phases.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata: raw_level[9:0], now_ms[41:10]
//  out_    | out | out_tvalid/out_tready| out_tdata: gesture[2:0], touched[3], sample_taken[4]
//  cfg_    | in  | cfg_we               | cfg_addr index, cfg_wdata value
//
// One transaction per cycle while out_tready is high; each result appears in the cycle after its input is accepted.
// The gate, hysteresis and phase update run in one combinational pass into the result register.
// in_tready is high while the result register is empty or being taken.
// Synchronous active-low reset restores register defaults and the idle phase.
module analog_touch_tap_hold_detector_core
  import attd_pkg::*;
#(
  parameter int TIME_BITS   = 32,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // raw_level, now_ms, zero fill
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // gesture, touched, sample_taken, zero fill
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  localparam logic [15:0] SampleMask = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

  logic [ThrW-1:0]      high_thr_r, low_thr_r;
  logic [MsW-1:0]       tap_gap_r, hold_r, sample_iv_r;
  logic [PhaseW-1:0]    phase_r, phase_nxt;
  logic                 level_r, level_nxt;
  logic [CountW-1:0]    count_r, count_nxt;
  logic [TIME_BITS-1:0] press_t_r, press_t_nxt;
  logic [TIME_BITS-1:0] sample_t_r, sample_t_nxt;
  logic                 out_valid_r;
  result_t              res_r, res_nxt;

  logic                 in_acc;
  logic [15:0]          raw;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] el_sample, el_press, el_press2;
  logic                 gate_ok, rise, hold_hit;
  logic [PhaseW-1:0]    ph1, ph2, ph3;
  logic [CountW-1:0]    cnt1, cnt2;
  logic [GestW-1:0]     gest;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign raw = {6'd0, in_tdata[RawW-1:0]} & SampleMask;
  assign now = TIME_BITS'({32'd0, in_tdata[RawW +: NowW]});

  assign el_sample = now - sample_t_r;
  assign el_press  = now - press_t_r;
  assign gate_ok   = !(el_sample < TIME_BITS'(sample_iv_r));

  // previous level always equals the stored filtered level between items
  always_comb begin
    level_nxt = level_r;
    if (!level_r && (raw > 16'(high_thr_r))) begin
      level_nxt = 1'b1;
    end else if (level_r && (raw < 16'(low_thr_r))) begin
      level_nxt = 1'b0;
    end
    rise = !level_r && level_nxt;

    ph1         = phase_r;
    cnt1        = count_r;
    press_t_nxt = press_t_r;
    el_press2   = el_press;
    if (rise) begin
      if ((phase_r == PH_COUNT) && (el_press < TIME_BITS'(tap_gap_r))) begin
        if (count_r < COUNT_MAX) begin
          cnt1 = count_r + 4'd1;
        end
      end else begin
        cnt1 = 4'd1;
        ph1  = PH_COUNT;
      end
      press_t_nxt = now;
      el_press2   = '0;
    end

    gest     = GEST_NONE;
    ph2      = ph1;
    cnt2     = cnt1;
    hold_hit = level_nxt && (ph1 == PH_COUNT) && (cnt1 == 4'd1)
               && (el_press2 > TIME_BITS'(hold_r));
    if (hold_hit) begin
      gest = GEST_HOLD;
      ph2  = PH_HOLD;
      cnt2 = '0;
    end

    ph3 = ph2;
    if (level_r && !level_nxt && (ph2 == PH_HOLD)) begin
      ph3 = PH_IDLE;
    end

    phase_nxt = ph3;
    count_nxt = cnt2;
    if ((ph3 == PH_COUNT) && !level_nxt && (el_press2 > TIME_BITS'(tap_gap_r))) begin
      case (cnt2)
        4'd1:    gest = GEST_SINGLE;
        4'd2:    gest = GEST_DOUBLE;
        4'd3:    gest = GEST_TRIPLE;
        default: gest = GEST_NONE;
      endcase
      count_nxt = '0;
      phase_nxt = PH_IDLE;
    end

    sample_t_nxt = now;

    if (gate_ok) begin
      res_nxt.gesture      = gest;
      res_nxt.touched      = level_nxt;
      res_nxt.sample_taken = 1'b1;
    end else begin
      res_nxt.gesture      = GEST_NONE;
      res_nxt.touched      = level_r;
      res_nxt.sample_taken = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r  <= HIGH_THR_RST;
      low_thr_r   <= LOW_THR_RST;
      tap_gap_r   <= TAP_GAP_RST;
      hold_r      <= HOLD_RST;
      sample_iv_r <= SAMPLE_IV_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HIGH_THR:  high_thr_r  <= cfg_wdata[ThrW-1:0];
        REG_LOW_THR:   low_thr_r   <= cfg_wdata[ThrW-1:0];
        REG_TAP_GAP:   tap_gap_r   <= cfg_wdata;
        REG_HOLD:      hold_r      <= cfg_wdata;
        REG_SAMPLE_IV: sample_iv_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      level_r    <= 1'b0;
      count_r    <= '0;
      press_t_r  <= '0;
      sample_t_r <= '0;
    end else if (in_acc && gate_ok) begin
      phase_r    <= phase_nxt;
      level_r    <= level_nxt;
      count_r    <= count_nxt;
      press_t_r  <= press_t_nxt;
      sample_t_r <= sample_t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, res_r.sample_taken, res_r.touched, res_r.gesture};

  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("phase register holds an unused code");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_COUNT |-> count_r == '0)
    else $error("tap count nonzero outside counting phase");

  a_ignored_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !gate_ok) |=> ($stable(phase_r) && $stable(count_r)
                              && $stable(level_r) && $stable(sample_t_r)))
    else $error("ignored transaction changed state");

  a_ignored_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.sample_taken) |-> res_r.gesture == GEST_NONE)
    else $error("ignored transaction reports a gesture");

endmodule

### test/tb_analog_touch_tap_hold_detector_core.sv
// Testbench for the touch tap and hold detector: directed and random gesture streams.
`timescale 1ns / 100ps

module tb_analog_touch_tap_hold_detector_core;
  import attd_pkg::*;

  class tap_gesture_scoreboard;
    logic [ThrW-1:0]   high_thr;
    logic [ThrW-1:0]   low_thr;
    logic [MsW-1:0]    tap_gap;
    logic [MsW-1:0]    hold_len;
    logic [MsW-1:0]    sample_iv;
    logic [PhaseW-1:0] phase;
    logic              level;
    logic              prev_level;
    logic [CountW-1:0] taps;
    logic [NowW-1:0]   press_ms;
    logic [NowW-1:0]   sample_ms;
    result_t           expected_q[$];
    int                errors;

    function new();
      high_thr   = HIGH_THR_RST;
      low_thr    = LOW_THR_RST;
      tap_gap    = TAP_GAP_RST;
      hold_len   = HOLD_RST;
      sample_iv  = SAMPLE_IV_RST;
      phase      = PH_IDLE;
      level      = 1'b0;
      prev_level = 1'b0;
      taps       = '0;
      press_ms   = '0;
      sample_ms  = '0;
      errors     = 0;
    endfunction

    function void write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
      case (addr)
        REG_HIGH_THR:  high_thr = data[ThrW-1:0];
        REG_LOW_THR:   low_thr = data[ThrW-1:0];
        REG_TAP_GAP:   tap_gap = data[MsW-1:0];
        REG_HOLD:      hold_len = data[MsW-1:0];
        REG_SAMPLE_IV: sample_iv = data[MsW-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(input logic [InDataW-1:0] d);
      logic [RawW-1:0] raw;
      logic [NowW-1:0] now;
      logic [NowW-1:0] since;
      result_t         r;
      raw = d[RawW-1:0];
      now = d[RawW +: NowW];
      r.gesture = GEST_NONE;
      r.sample_taken = 1'b0;
      since = now - sample_ms;
      if (since < sample_iv) begin
        r.touched = level;
        expected_q.push_back(r);
        return;
      end
      sample_ms = now;

      if (!level && raw > high_thr) level = 1'b1;
      else if (level && raw < low_thr) level = 1'b0;

      since = now - press_ms;
      if (!prev_level && level) begin
        if (phase == PH_COUNT && since < tap_gap) begin
          if (taps < COUNT_MAX) taps++;
        end else begin
          taps = CountW'(1);
          phase = PH_COUNT;
        end
        press_ms = now;
      end

      since = now - press_ms;
      if (level && phase == PH_COUNT && taps == 1 && since > hold_len) begin
        r.gesture = GEST_HOLD;
        phase = PH_HOLD;
        taps = '0;
      end

      if (prev_level && !level && phase == PH_HOLD) phase = PH_IDLE;

      if (phase == PH_COUNT && !level && since > tap_gap) begin
        r.gesture = (taps >= 1 && taps <= 3) ? GestW'(taps) : GEST_NONE;
        taps = '0;
        phase = PH_IDLE;
      end

      prev_level = level;
      r.touched = level;
      r.sample_taken = 1'b1;
      expected_q.push_back(r);
    endfunction

    function void check_result(input logic [OutDataW-1:0] d);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result %h with no transaction pending", $time, d);
        return;
      end
      exp_r = expected_q.pop_front();
      if (d[GestW-1:0] !== exp_r.gesture) begin
        errors++;
        $display("%0t: gesture expected %0d got %0d", $time, exp_r.gesture, d[GestW-1:0]);
      end
      if (d[GestW] !== exp_r.touched) begin
        errors++;
        $display("%0t: touched expected %0d got %0d", $time, exp_r.touched, d[GestW]);
      end
      if (d[GestW+1] !== exp_r.sample_taken) begin
        errors++;
        $display("%0t: sample_taken expected %0d got %0d", $time, exp_r.sample_taken,
                 d[GestW+1]);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;   // raw_level, now_ms, zero fill
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;  // gesture, touched, sample_taken, zero fill
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  tap_gesture_scoreboard sb = new();
  bit                    flow_free;
  int                    items_sent;
  logic [NowW-1:0]       cur_ms;

  int unsigned dir_raw[23] = '{1023, 1023, 700, 701, 0, 300, 299, 0,
                               1023, 0, 1023, 0, 0,
                               1023, 0, 1023, 0, 1023, 0, 0,
                               1023, 1023, 0};
  int unsigned dir_ms[23]  = '{0, 29, 30, 60, 70, 100, 130, 700,
                               800, 850, 900, 950, 1500,
                               1600, 1650, 1700, 1750, 1800, 1850, 2400,
                               2500, 4600, 4700};

  analog_touch_tap_hold_detector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL analog_touch_tap_hold_detector_core");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  function automatic int pick_gap();
    int r;
    if (flow_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  initial begin
    int n;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      n = pick_gap();
      if (n == 0) begin
        out_tready <= 1'b1;
        @(negedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  function automatic logic [RawW-1:0] hi_level();
    if (sb.high_thr == '1) return '1;
    return RawW'($urandom_range(sb.high_thr + 1, 1023));
  endfunction

  function automatic logic [RawW-1:0] lo_level();
    if (sb.low_thr == '0) return '0;
    return RawW'($urandom_range(0, sb.low_thr - 1));
  endfunction

  function automatic logic [RawW-1:0] mid_level();
    return RawW'($urandom_range(sb.low_thr, sb.high_thr));
  endfunction

  task automatic send(input logic [RawW-1:0] raw, input logic [NowW-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(InDataW - RawW - NowW){1'b0}}, now, raw};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic step_send(input logic [RawW-1:0] raw);
    cur_ms += sb.sample_iv + $urandom_range(0, 20);
    send(raw, cur_ms);
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    sb.write_reg(addr, data);
    @(negedge clk);
  endtask

  task automatic apply_config(input logic [CfgDataW-1:0] high, input logic [CfgDataW-1:0] low,
                              input logic [CfgDataW-1:0] gap, input logic [CfgDataW-1:0] hold,
                              input logic [CfgDataW-1:0] iv);
    drain();
    write_reg(REG_HIGH_THR, high);
    write_reg(REG_LOW_THR, low);
    write_reg(REG_TAP_GAP, gap);
    write_reg(REG_HOLD, hold);
    write_reg(REG_SAMPLE_IV, iv);
    cfg_we <= 1'b0;
  endtask

  // press/release sequence with random content, now and then broken by a late press
  task automatic tap_burst();
    int  r;
    int  taps;
    int  extra;
    bit  hold;
    r = $urandom_range(0, 9);
    taps = (r < 7) ? $urandom_range(1, 3) :
           (r < 9) ? $urandom_range(4, 6) : $urandom_range(14, 17);
    hold = (taps == 1) && ($urandom_range(0, 2) == 0);
    for (int t = 0; t < taps; t++) begin
      if ($urandom_range(0, 9) == 0) cur_ms += sb.tap_gap + $urandom_range(1, 40);
      step_send(hi_level());
      extra = $urandom_range(0, 2);
      repeat (extra) step_send($urandom_range(0, 1) ? hi_level() : mid_level());
      if (hold) begin
        cur_ms += sb.hold_len + $urandom_range(1, 60);
        send(hi_level(), cur_ms);
      end
      step_send(lo_level());
    end
    cur_ms += sb.tap_gap + $urandom_range(1, 100);
    send($urandom_range(0, 1) ? lo_level() : mid_level(), cur_ms);
  endtask

  task automatic run_items(input int count);
    int stop;
    int r;
    stop = items_sent + count;
    while (items_sent < stop) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        cur_ms += $urandom_range(0, sb.sample_iv + 10);
        send(RawW'($urandom_range(0, 1023)), cur_ms);
      end else if (r == 1) begin
        cur_ms = $urandom;
        send(RawW'($urandom_range(0, 1023)), cur_ms);
      end else begin
        tap_burst();
      end
    end
  endtask

  initial begin
    logic [ThrW-1:0] h;
    logic [ThrW-1:0] l;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    flow_free = 1'b0;
    items_sent = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default settings: early items, threshold edges, single/double/triple, hold
    foreach (dir_raw[i]) send(RawW'(dir_raw[i]), NowW'(dir_ms[i]));
    cur_ms = dir_ms[22];
    in_tvalid <= 1'b0;

    apply_config(1023, 0, 500, 2000, 30);
    run_items(30);
    in_tvalid <= 1'b0;
    apply_config(0, 1023, 500, 2000, 30);
    run_items(30);
    in_tvalid <= 1'b0;
    apply_config(600, 200, 0, 1, 0);
    run_items(40);
    in_tvalid <= 1'b0;
    flow_free = 1'b1;
    apply_config(600, 200, 65535, 65535, 65535);
    run_items(40);
    in_tvalid <= 1'b0;

    drain();
    for (int a = REG_SAMPLE_IV + 1; a < (1 << CfgAddrW); a++) begin
      write_reg(CfgAddrW'(a), CfgDataW'($urandom));
    end
    cfg_we <= 1'b0;
    run_items(20);
    in_tvalid <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      flow_free = (p == 2);
      if (p == 3) cur_ms = 32'hFFFF_FE00;
      h = ThrW'($urandom_range(300, 1000));
      l = ThrW'($urandom_range(0, h));
      apply_config({6'($urandom), h}, {6'($urandom), l}, CfgDataW'($urandom_range(150, 3000)),
                   CfgDataW'($urandom_range(50, 5000)), CfgDataW'($urandom_range(0, 60)));
      run_items(40);
      in_tvalid <= 1'b0;
    end

    drain();
    repeat (5) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS analog_touch_tap_hold_detector_core");
    end else begin
      $display("FAIL analog_touch_tap_hold_detector_core");
    end
    $finish;
  end

endmodule
